@@ rtl/epf_pkg.sv @@
// Shared types, constants and codes of the Euler path finder.
`default_nettype none
package epf_pkg;

  localparam int MaxVertices = 16;
  localparam int MaxEdges    = 63;
  localparam int BufDepth    = MaxEdges + 2;
  localparam int Cells       = MaxVertices * MaxVertices;

  localparam logic [1:0] ST_PATH    = 2'd0;
  localparam logic [1:0] ST_NO_PATH = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_RUN   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } opcode_e;

  typedef enum logic [4:0] {
    S_IDLE, S_ADD_WR, S_SCAN, S_SCAN_END, S_COPY,
    S_RD_AB, S_WR_AB, S_RD_BA, S_WR_BA, S_WALK_INIT,
    S_WSCAN_RD, S_WSCAN_CK, S_WR_VU, S_RD_UV, S_WR_UV, S_PUSH,
    S_NOEDGE, S_POP_WAIT, S_LEFT, S_LEFT_END, S_SEAM, S_CNT, S_CNT_CHK,
    S_EM_RD, S_EM_LD, S_FAIL_NP, S_FAIL_EMPTY
  } state_e;

  typedef enum logic [4:0] {
    C_NONE, C_ADD_RD, C_ADD_WR, C_CLEAR, C_RUN_INIT, C_SCAN, C_COPY_INIT,
    C_COPY, C_RD_AB, C_WR_AB_INC, C_RD_BA, C_WR_BA_INC, C_WALK_INIT,
    C_RD_UV, C_U_INC, C_RD_VU, C_WR_VU_DEC, C_WR_UV_DEC, C_PUSH, C_POP,
    C_TOP_LOAD, C_LEFT_INIT, C_LEFT, C_SEAM_INIT, C_SEAM, C_CNT,
    C_EMIT_INIT, C_EM_RD, C_EM_LD, C_FAIL_NP, C_FAIL_EMPTY
  } cmd_e;

  typedef struct packed {
    logic scan_done;
    logic odd_many;
    logic odd_two;
    logic start_found;
    logic sweep_last;
    logic u_end;
    logic work_nz;
    logic stack_full;
    logic circ_full;
    logic stack_empty;
    logic left_err;
    logic seam_do;
    logic seam_last;
    logic cnt_bad;
    logic out_free;
    logic em_last;
  } dp_status_t;

endpackage
`default_nettype wire

@@ rtl/epf_ctrl.sv @@
// Controller state machine that sequences loads, the walk and the emission.
`default_nettype none
module epf_ctrl (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  input  wire  [1:0]               opcode_i,
  input  wire  epf_pkg::dp_status_t st_i,
  output epf_pkg::cmd_e            cmd_o
);
  import epf_pkg::*;

  state_e state_q, state_d;
  opcode_e op;

  assign op = opcode_e'(opcode_i);
  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (op)
            OP_ADD:   state_d = S_ADD_WR;
            OP_RUN:   state_d = S_SCAN;
            OP_CLEAR: state_d = S_IDLE;
            OP_NOP:   state_d = S_IDLE;
          endcase
        end
      end
      S_ADD_WR:   state_d = S_IDLE;
      S_SCAN:     if (st_i.scan_done) state_d = S_SCAN_END;
      S_SCAN_END: begin
        if (st_i.odd_many) state_d = S_FAIL_NP;
        else if (!st_i.start_found) state_d = S_FAIL_EMPTY;
        else state_d = S_COPY;
      end
      S_COPY: begin
        if (st_i.sweep_last) state_d = st_i.odd_two ? S_RD_AB : S_WALK_INIT;
      end
      S_RD_AB:     state_d = S_WR_AB;
      S_WR_AB:     state_d = S_RD_BA;
      S_RD_BA:     state_d = S_WR_BA;
      S_WR_BA:     state_d = S_WALK_INIT;
      S_WALK_INIT: state_d = S_WSCAN_RD;
      S_WSCAN_RD:  state_d = st_i.u_end ? S_NOEDGE : S_WSCAN_CK;
      S_WSCAN_CK: begin
        if (!st_i.work_nz) state_d = S_WSCAN_RD;
        else if (st_i.stack_full) state_d = S_FAIL_NP;
        else state_d = S_WR_VU;
      end
      S_WR_VU:    state_d = S_RD_UV;
      S_RD_UV:    state_d = S_WR_UV;
      S_WR_UV:    state_d = S_PUSH;
      S_PUSH:     state_d = S_WSCAN_RD;
      S_NOEDGE:   state_d = st_i.circ_full ? S_FAIL_NP : S_POP_WAIT;
      S_POP_WAIT: state_d = st_i.stack_empty ? S_LEFT : S_WSCAN_RD;
      S_LEFT:     if (st_i.sweep_last) state_d = S_LEFT_END;
      S_LEFT_END: begin
        if (st_i.left_err) state_d = S_FAIL_NP;
        else if (st_i.seam_do) state_d = S_SEAM;
        else state_d = S_CNT_CHK;
      end
      S_SEAM:     if (st_i.seam_last) state_d = S_CNT;
      S_CNT:      state_d = S_CNT_CHK;
      S_CNT_CHK:  state_d = st_i.cnt_bad ? S_FAIL_NP : S_EM_RD;
      S_EM_RD:    state_d = S_EM_LD;
      S_EM_LD: begin
        if (st_i.out_free) state_d = st_i.em_last ? S_IDLE : S_EM_RD;
      end
      S_FAIL_NP:    if (st_i.out_free) state_d = S_IDLE;
      S_FAIL_EMPTY: if (st_i.out_free) state_d = S_IDLE;
      default:      state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = C_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (op)
            OP_ADD:   cmd_o = C_ADD_RD;
            OP_RUN:   cmd_o = C_RUN_INIT;
            OP_CLEAR: cmd_o = C_CLEAR;
            OP_NOP:   cmd_o = C_NONE;
          endcase
        end
      end
      S_ADD_WR: cmd_o = C_ADD_WR;
      S_SCAN:   if (!st_i.scan_done) cmd_o = C_SCAN;
      S_SCAN_END: begin
        if (!st_i.odd_many && st_i.start_found) cmd_o = C_COPY_INIT;
      end
      S_COPY:      cmd_o = C_COPY;
      S_RD_AB:     cmd_o = C_RD_AB;
      S_WR_AB:     cmd_o = C_WR_AB_INC;
      S_RD_BA:     cmd_o = C_RD_BA;
      S_WR_BA:     cmd_o = C_WR_BA_INC;
      S_WALK_INIT: cmd_o = C_WALK_INIT;
      S_WSCAN_RD:  if (!st_i.u_end) cmd_o = C_RD_UV;
      S_WSCAN_CK: begin
        if (!st_i.work_nz) cmd_o = C_U_INC;
        else if (!st_i.stack_full) cmd_o = C_RD_VU;
      end
      S_WR_VU:    cmd_o = C_WR_VU_DEC;
      S_RD_UV:    cmd_o = C_RD_UV;
      S_WR_UV:    cmd_o = C_WR_UV_DEC;
      S_PUSH:     cmd_o = C_PUSH;
      S_NOEDGE:   if (!st_i.circ_full) cmd_o = C_POP;
      S_POP_WAIT: cmd_o = st_i.stack_empty ? C_LEFT_INIT : C_TOP_LOAD;
      S_LEFT:     cmd_o = C_LEFT;
      S_LEFT_END: begin
        if (!st_i.left_err) cmd_o = st_i.seam_do ? C_SEAM_INIT : C_CNT;
      end
      S_SEAM:     cmd_o = C_SEAM;
      S_CNT:      cmd_o = C_CNT;
      S_CNT_CHK:  if (!st_i.cnt_bad) cmd_o = C_EMIT_INIT;
      S_EM_RD:    cmd_o = C_EM_RD;
      S_EM_LD:    if (st_i.out_free) cmd_o = C_EM_LD;
      S_FAIL_NP:    if (st_i.out_free) cmd_o = C_FAIL_NP;
      S_FAIL_EMPTY: if (st_i.out_free) cmd_o = C_FAIL_EMPTY;
      default:      cmd_o = C_NONE;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/epf_dp.sv @@
// Datapath: graph memories, walk stack, circuit buffer, counters and output register.
`default_nettype none
module epf_dp (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire  epf_pkg::cmd_e cmd_i,
  output epf_pkg::dp_status_t st_o,
  input  wire  [3:0]          row_vertex_i,
  input  wire  [3:0]          neighbor_vertex_i,
  input  wire                 cfg_we_i,
  input  wire  [4:0]          cfg_data_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output logic [1:0]          status_o,
  output logic [3:0]          path_vertex_o,
  output logic [5:0]          edge_total_o,
  output logic                last_o
);
  import epf_pkg::*;

  logic [6:0] edge_mem  [Cells];
  logic [6:0] work_mem  [Cells];
  logic [3:0] stack_mem [BufDepth];
  logic [3:0] circ_mem  [BufDepth];

  logic [4:0]       vcount_q;
  logic [Cells-1:0] valid_q;
  logic [6:0]       entry_q [MaxVertices];
  logic [6:0]       total_q;
  logic [6:0]       sdepth_q, clen_q;
  logic             out_valid_q;

  logic [6:0] edge_rd_q, work_rd_q;
  logic       edge_vld_q;
  logic [3:0] stack_rd_q, circ_rd_q;
  logic [3:0] row_q, nb_q;
  logic [8:0] idx_q;
  logic [1:0] odd_q;
  logic [3:0] a_q, b_q, start_q, v_q, prev_q;
  logic       start_found_q, left_err_q, found_q;
  logic [6:0] seam_q, cnt_q, ei_q, k_q;
  logic [1:0] status_q;
  logic [3:0] pv_q;
  logic [5:0] et_q;
  logic       last_q;

  logic [4:0] n;
  logic [3:0] u;
  logic [3:0] si;
  logic [7:0] prev_addr;
  logic       add_ok, out_free, pair_match, out_load;
  logic [6:0] edge_old, seam_next, ei_next;
  logic [7:0] work_ra, work_wa;
  logic       work_re, work_we;
  logic [6:0] work_wd;

  assign n         = (vcount_q > 5'(MaxVertices)) ? 5'(MaxVertices) : vcount_q;
  assign u         = idx_q[3:0];
  assign si        = idx_q[3:0];
  assign prev_addr = 8'(idx_q - 9'd1);
  assign add_ok    = total_q < 7'(2 * MaxEdges);
  assign edge_old  = edge_vld_q ? edge_rd_q : 7'd0;
  assign out_free  = !out_valid_q || out_ready_i;
  assign out_load  = (cmd_i == C_EM_LD) || (cmd_i == C_FAIL_NP) || (cmd_i == C_FAIL_EMPTY);
  assign pair_match = ((prev_q == a_q) && (circ_rd_q == b_q)) ||
                      ((prev_q == b_q) && (circ_rd_q == a_q));
  assign seam_next = seam_q + 7'd1;
  assign ei_next   = (ei_q + 7'd1 == cnt_q) ? 7'd0 : ei_q + 7'd1;

  // Status to the controller.
  always_comb begin
    st_o.scan_done   = idx_q >= {4'd0, n};
    st_o.odd_many    = odd_q == 2'd3;
    st_o.odd_two     = odd_q == 2'd2;
    st_o.start_found = start_found_q;
    st_o.sweep_last  = idx_q == 9'(Cells);
    st_o.u_end       = idx_q >= {4'd0, n};
    st_o.work_nz     = work_rd_q != 7'd0;
    st_o.stack_full  = sdepth_q >= 7'(BufDepth);
    st_o.circ_full   = clen_q >= 7'(BufDepth);
    st_o.stack_empty = sdepth_q == 7'd0;
    st_o.left_err    = left_err_q;
    st_o.seam_do     = (odd_q == 2'd2) && (clen_q >= 7'd2);
    st_o.seam_last   = idx_q == {2'd0, clen_q};
    st_o.cnt_bad     = (cnt_q == 7'd0) || (cnt_q > 7'(MaxEdges + 1));
    st_o.out_free    = out_free;
    st_o.em_last     = (k_q + 7'd1) == cnt_q;
  end

  // Work matrix port selection.
  always_comb begin
    work_ra = 8'd0;
    work_re = 1'b0;
    work_wa = 8'd0;
    work_we = 1'b0;
    work_wd = 7'd0;
    unique case (cmd_i)
      C_RD_AB: begin work_ra = {a_q, b_q}; work_re = 1'b1; end
      C_RD_BA: begin work_ra = {b_q, a_q}; work_re = 1'b1; end
      C_RD_UV: begin work_ra = {u, v_q}; work_re = 1'b1; end
      C_RD_VU: begin work_ra = {v_q, u}; work_re = 1'b1; end
      C_LEFT: begin
        work_ra = idx_q[7:0];
        work_re = !idx_q[8];
      end
      C_COPY: begin
        work_wa = prev_addr;
        work_we = idx_q != 9'd0;
        work_wd = edge_old;
      end
      C_WR_AB_INC: begin work_wa = {a_q, b_q}; work_we = 1'b1; work_wd = work_rd_q + 7'd1; end
      C_WR_BA_INC: begin work_wa = {b_q, a_q}; work_we = 1'b1; work_wd = work_rd_q + 7'd1; end
      C_WR_VU_DEC: begin work_wa = {v_q, u}; work_we = 1'b1; work_wd = work_rd_q - 7'd1; end
      C_WR_UV_DEC: begin work_wa = {u, v_q}; work_we = 1'b1; work_wd = work_rd_q - 7'd1; end
      default: ;
    endcase
  end

  // Memories.
  always_ff @(posedge clk_i) begin
    if (cmd_i == C_ADD_RD) begin
      edge_rd_q  <= edge_mem[{row_vertex_i, neighbor_vertex_i}];
      edge_vld_q <= valid_q[{row_vertex_i, neighbor_vertex_i}];
    end else if (cmd_i == C_COPY && !idx_q[8]) begin
      edge_rd_q  <= edge_mem[idx_q[7:0]];
      edge_vld_q <= valid_q[idx_q[7:0]];
    end
    if (cmd_i == C_ADD_WR && add_ok) begin
      edge_mem[{row_q, nb_q}] <= edge_old + 7'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (work_re) work_rd_q <= work_mem[work_ra];
    if (work_we) work_mem[work_wa] <= work_wd;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == C_WALK_INIT) stack_mem[7'd0] <= start_q;
    if (cmd_i == C_PUSH) stack_mem[sdepth_q] <= u;
    if (cmd_i == C_POP && sdepth_q >= 7'd2) stack_rd_q <= stack_mem[sdepth_q - 7'd2];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == C_POP) circ_mem[clen_q] <= v_q;
    if (cmd_i == C_SEAM && idx_q < {2'd0, clen_q}) circ_rd_q <= circ_mem[idx_q[6:0]];
    else if (cmd_i == C_EM_RD) circ_rd_q <= circ_mem[ei_q];
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q    <= 5'(MaxVertices);
      valid_q     <= '0;
      total_q     <= 7'd0;
      sdepth_q    <= 7'd0;
      clen_q      <= 7'd0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MaxVertices; i++) entry_q[i] <= 7'd0;
    end else begin
      if (cfg_we_i) vcount_q <= cfg_data_i;
      if (cmd_i == C_CLEAR) begin
        valid_q <= '0;
        total_q <= 7'd0;
        sdepth_q <= 7'd0;
        clen_q <= 7'd0;
        for (int i = 0; i < MaxVertices; i++) entry_q[i] <= 7'd0;
      end
      if (cmd_i == C_ADD_WR && add_ok) begin
        valid_q[{row_q, nb_q}] <= 1'b1;
        total_q <= total_q + 7'd1;
        for (int i = 0; i < MaxVertices; i++) begin
          if (row_q == 4'(i)) entry_q[i] <= entry_q[i] + 7'd1;
        end
      end
      unique case (cmd_i)
        C_WALK_INIT: begin sdepth_q <= 7'd1; clen_q <= 7'd0; end
        C_PUSH:      sdepth_q <= sdepth_q + 7'd1;
        C_POP: begin
          sdepth_q <= sdepth_q - 7'd1;
          clen_q   <= clen_q + 7'd1;
        end
        default: ;
      endcase
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Working registers of a run.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      C_ADD_RD: begin row_q <= row_vertex_i; nb_q <= neighbor_vertex_i; end
      C_RUN_INIT: begin
        idx_q <= 9'd0;
        odd_q <= 2'd0;
        start_found_q <= 1'b0;
      end
      C_SCAN: begin
        if (entry_q[si][0]) begin
          if (odd_q == 2'd0) a_q <= si;
          else b_q <= si;
          if (odd_q != 2'd3) odd_q <= odd_q + 2'd1;
        end
        if (!start_found_q && entry_q[si] != 7'd0) begin
          start_q <= si;
          start_found_q <= 1'b1;
        end
        idx_q <= idx_q + 9'd1;
      end
      C_COPY_INIT: idx_q <= 9'd0;
      C_COPY:      idx_q <= idx_q + 9'd1;
      C_WALK_INIT: begin v_q <= start_q; idx_q <= 9'd0; end
      C_U_INC:     idx_q <= idx_q + 9'd1;
      C_PUSH:      begin v_q <= u; idx_q <= 9'd0; end
      C_TOP_LOAD:  begin v_q <= stack_rd_q; idx_q <= 9'd0; end
      C_LEFT_INIT: begin idx_q <= 9'd0; left_err_q <= 1'b0; found_q <= 1'b0; end
      C_LEFT: begin
        if (idx_q != 9'd0 && {1'b0, prev_addr[7:4]} < n && {1'b0, prev_addr[3:0]} < n &&
            work_rd_q != 7'd0) begin
          left_err_q <= 1'b1;
        end
        idx_q <= idx_q + 9'd1;
      end
      C_SEAM_INIT: idx_q <= 9'd0;
      C_SEAM: begin
        // The pair compared here is the previous and the just-read buffer entry.
        if (idx_q >= 9'd2 && !found_q && pair_match) begin
          found_q <= 1'b1;
          seam_q  <= 7'(idx_q - 9'd2);
        end
        if (idx_q != 9'd0) prev_q <= circ_rd_q;
        idx_q <= idx_q + 9'd1;
      end
      C_CNT: cnt_q <= found_q ? clen_q - 7'd1 : clen_q;
      C_EMIT_INIT: begin
        k_q <= 7'd0;
        if (!found_q) ei_q <= 7'd0;
        else ei_q <= (seam_next == cnt_q) ? 7'd0 : seam_next;
      end
      C_EM_LD: begin
        k_q  <= k_q + 7'd1;
        ei_q <= ei_next;
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      C_EM_LD: begin
        status_q <= ST_PATH;
        pv_q     <= circ_rd_q;
        et_q     <= 6'(cnt_q - 7'd1);
        last_q   <= (k_q + 7'd1) == cnt_q;
      end
      C_FAIL_NP: begin
        status_q <= ST_NO_PATH; pv_q <= 4'd0; et_q <= 6'd0; last_q <= 1'b1;
      end
      C_FAIL_EMPTY: begin
        status_q <= ST_EMPTY; pv_q <= 4'd0; et_q <= 6'd0; last_q <= 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign path_vertex_o = pv_q;
  assign edge_total_o  = et_q;
  assign last_o        = last_q;

endmodule
`default_nettype wire

@@ rtl/euler_path_finder.sv @@
// Top level of the Euler path finder: controller and datapath.
// An add request reads the addressed cell in idle and writes it in S_ADD_WR; a clear
// or no-op request is handled in idle. A run does a degree scan, a matrix copy, a walk
// of up to 16 column reads per walk step, a leftover check, a rotation search over the
// circuit entries and the emission of the path vertices.
// Reset is asynchronous, active low: the graph is empty and vertex_count is 16.
`default_nettype none
module euler_path_finder (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  wire  [1:0] opcode_i,
  input  wire  [3:0] row_vertex_i,
  input  wire  [3:0] neighbor_vertex_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output logic [1:0] status_o,
  output logic [3:0] path_vertex_o,
  output logic [5:0] edge_total_o,
  output logic       last_o,
  input  wire        cfg_we_i,
  input  wire  [4:0] cfg_data_i
);
  import epf_pkg::*;

  cmd_e       cmd;
  dp_status_t st;

  epf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  epf_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .st_o              (st),
    .row_vertex_i      (row_vertex_i),
    .neighbor_vertex_i (neighbor_vertex_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_data_i        (cfg_data_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .path_vertex_o     (path_vertex_o),
    .edge_total_o      (edge_total_o),
    .last_o            (last_o)
  );

endmodule
`default_nettype wire
